// ----- sv/assert_macros.svh -----
// Assertion macros for the RTL of the frustum cull block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define AFC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define AFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- sv/afc_pkg.sv -----
// ----------------------------------------------------------------------------
// afc_pkg
// Types and constants shared by the box versus frustum culling pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package afc_pkg;

    localparam int NumPlanes = 4;
    localparam int NumAxes   = 3;
    localparam int CoordW    = 20;
    localparam int CompW     = 16;
    localparam int DistW     = 21;
    localparam int NormalW   = NumAxes * CompW;
    localparam int ProdW     = CoordW + CompW;
    localparam int SumW      = ProdW + 2;
    localparam int DistShift = 14;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = NormalW;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] RegPlaneANormal = 3'd0;
    localparam logic [CfgIdxW-1:0] RegPlaneADist   = 3'd1;
    localparam logic [CfgIdxW-1:0] RegPlaneBNormal = 3'd2;
    localparam logic [CfgIdxW-1:0] RegPlaneBDist   = 3'd3;
    localparam logic [CfgIdxW-1:0] RegPlaneCNormal = 3'd4;
    localparam logic [CfgIdxW-1:0] RegPlaneCDist   = 3'd5;
    localparam logic [CfgIdxW-1:0] RegPlaneDNormal = 3'd6;
    localparam logic [CfgIdxW-1:0] RegPlaneDDist   = 3'd7;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic signed [CompW-1:0]  comp_t;
    typedef logic signed [DistW-1:0]  dist_t;
    typedef logic signed [ProdW-1:0]  prod_t;
    typedef logic signed [SumW-1:0]   sum_t;

    typedef struct packed {
        coord_t min_x;
        coord_t min_y;
        coord_t min_z;
        coord_t max_x;
        coord_t max_y;
        coord_t max_z;
    } box_t;

    typedef struct packed {
        logic [NormalW-1:0] normal;
        dist_t              distance;
    } plane_t;

    // Load enables for the three datapath stages inside each plane unit.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } afc_adv_t;

endpackage

`default_nettype wire

// ----- sv/afc_box_if.sv -----
// ----------------------------------------------------------------------------
// afc_box_if
// Valid/ready channel that carries one axis-aligned box per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface afc_box_if;
    import afc_pkg::*;

    logic   valid;
    logic   ready;
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;

    modport source (
        output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        input  ready
    );

    modport sink (
        input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        output ready
    );

endinterface

`default_nettype wire

// ----- sv/afc_result_if.sv -----
// ----------------------------------------------------------------------------
// afc_result_if
// Valid/ready channel that carries one cull decision per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface afc_result_if;

    logic valid;
    logic ready;
    logic culled;

    modport source (
        output valid, culled,
        input  ready
    );

    modport sink (
        input  valid, culled,
        output ready
    );

endinterface

`default_nettype wire

// ----- sv/afc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// afc_cfg_regs
// Holds the normal and distance of the four frustum planes.
// ----------------------------------------------------------------------------
`default_nettype none

module afc_cfg_regs (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      cfg_we,
    input  wire logic [afc_pkg::CfgIdxW-1:0]               cfg_index,
    input  wire logic [afc_pkg::CfgDataW-1:0]              cfg_data,
    output afc_pkg::plane_t [afc_pkg::NumPlanes-1:0]       planes
);
    import afc_pkg::*;

    plane_t [NumPlanes-1:0] planes_reg;
    plane_t [NumPlanes-1:0] planes_next;
    logic   [NormalW-1:0]   normal_val;
    dist_t                  dist_val;

    assign normal_val = cfg_data[NormalW-1:0];
    assign dist_val   = dist_t'(cfg_data[DistW-1:0]);

    always_comb
    begin
        planes_next = planes_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                RegPlaneANormal: planes_next[0].normal   = normal_val;
                RegPlaneADist:   planes_next[0].distance = dist_val;
                RegPlaneBNormal: planes_next[1].normal   = normal_val;
                RegPlaneBDist:   planes_next[1].distance = dist_val;
                RegPlaneCNormal: planes_next[2].normal   = normal_val;
                RegPlaneCDist:   planes_next[2].distance = dist_val;
                RegPlaneDNormal: planes_next[3].normal   = normal_val;
                RegPlaneDDist:   planes_next[3].distance = dist_val;
                default:         planes_next = planes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            planes_reg <= '0;
        end
        else
        begin
            planes_reg <= planes_next;
        end
    end

    assign planes = planes_reg;

endmodule

`default_nettype wire

// ----- sv/afc_plane_test.sv -----
// ----------------------------------------------------------------------------
// afc_plane_test
// Three-stage datapath that tests one box against one plane: positive-vertex
// select and products, sum of products, compare against the scaled distance.
// ----------------------------------------------------------------------------
`default_nettype none

module afc_plane_test (
    input  wire logic             clk,
    input  afc_pkg::box_t         box,
    input  afc_pkg::plane_t       plane,
    input  afc_pkg::afc_adv_t     adv,
    output logic                  outside
);
    import afc_pkg::*;

    comp_t  n         [NumAxes];
    coord_t lo        [NumAxes];
    coord_t hi        [NumAxes];
    coord_t corner    [NumAxes];
    prod_t  prod_next [NumAxes];
    prod_t  prod_reg  [NumAxes];
    sum_t   sum_next;
    sum_t   sum_reg;
    sum_t   thresh;
    logic   outside_next;
    logic   outside_reg;

    assign lo[0] = box.min_x;
    assign lo[1] = box.min_y;
    assign lo[2] = box.min_z;
    assign hi[0] = box.max_x;
    assign hi[1] = box.max_y;
    assign hi[2] = box.max_z;

    // The positive vertex takes the maximum unless the normal component is negative.
    always_comb
    begin
        for (int j = 0; j < NumAxes; j++)
        begin
            n[j]         = comp_t'(plane.normal[j*CompW +: CompW]);
            corner[j]    = n[j][CompW-1] ? lo[j] : hi[j];
            prod_next[j] = prod_t'(n[j]) * prod_t'(corner[j]);
        end
    end

    assign sum_next     = sum_t'(prod_reg[0]) + sum_t'(prod_reg[1]) + sum_t'(prod_reg[2]);
    assign thresh       = sum_t'(plane.distance) <<< DistShift;
    assign outside_next = sum_reg < thresh;

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            for (int j = 0; j < NumAxes; j++)
            begin
                prod_reg[j] <= prod_next[j];
            end
        end
        if (adv.s2)
        begin
            sum_reg <= sum_next;
        end
        if (adv.s3)
        begin
            outside_reg <= outside_next;
        end
    end

    assign outside = outside_reg;

endmodule

`default_nettype wire

// ----- sv/aabb_frustum_cull.sv -----
// ----------------------------------------------------------------------------
// aabb_frustum_cull
// Axis-aligned box versus four-plane frustum test, fully pipelined.
// ----------------------------------------------------------------------------
// The block takes one box per cycle while the pipeline is not stalled and
// returns one cull flag per box, in order. Each box passes through four
// register stages: positive-vertex products, sum of products, distance
// compare per plane, and the output register that ORs the four plane flags.
// Each stage holds its data while the stage after it is full and stalled,
// so bubbles are squeezed out and a stall on the result side reaches the
// box side only once every stage is full. Plane registers reset to zero,
// which never culls; the user must write them only while no box is in
// flight, and the block itself does not enforce it.
`default_nettype none

`include "assert_macros.svh"

module aabb_frustum_cull (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [afc_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [afc_pkg::CfgDataW-1:0]  cfg_data,
    afc_box_if.sink                            box,
    afc_result_if.source                       result
);
    import afc_pkg::*;

    plane_t [NumPlanes-1:0] planes;
    box_t                   box_data;
    afc_adv_t               adv;
    logic   [NumPlanes-1:0] outside;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;
    logic culled_reg;

    afc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .planes    (planes)
    );

    assign box_data.min_x = box.box_min_x;
    assign box_data.min_y = box.box_min_y;
    assign box_data.min_z = box.box_min_z;
    assign box_data.max_x = box.box_max_x;
    assign box_data.max_y = box.box_max_y;
    assign box_data.max_z = box.box_max_z;

    // A stage can take new data when it is empty or its content moves on.
    assign rdy4 = !v4_reg || result.ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign adv.s1 = rdy1 && box.valid;
    assign adv.s2 = rdy2 && v1_reg;
    assign adv.s3 = rdy3 && v2_reg;

    assign v1_next = rdy1 ? box.valid : v1_reg;
    assign v2_next = rdy2 ? v1_reg    : v2_reg;
    assign v3_next = rdy3 ? v2_reg    : v3_reg;
    assign v4_next = rdy4 ? v3_reg    : v4_reg;

    for (genvar p = 0; p < NumPlanes; p++)
    begin : g_plane
        afc_plane_test u_plane_test (
            .clk     (clk),
            .box     (box_data),
            .plane   (planes[p]),
            .adv     (adv),
            .outside (outside[p])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            culled_reg <= |outside;
        end
    end

    assign box.ready     = rdy1;
    assign result.valid  = v4_reg;
    assign result.culled = culled_reg;

    // A ready result side never blocks the box side.
    `AFC_ASSERT_SAME(a_ready_passes, clk, rst_n, result.ready, box.ready)
    // An accepted box lands in the first stage.
    `AFC_ASSERT_NEXT(a_accept_fills, clk, rst_n, box.valid && box.ready, v1_reg)
    // A first-stage item that can move reaches the second stage.
    `AFC_ASSERT_NEXT(a_stage_moves, clk, rst_n, v1_reg && rdy2, v2_reg)
    // With nothing behind it, a delivered result leaves the output empty.
    `AFC_ASSERT_NEXT(a_out_drains, clk, rst_n,
        result.valid && result.ready && !v3_reg, !result.valid)

endmodule

`default_nettype wire

// ----- sim/tb_aabb_frustum_cull.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aabb_frustum_cull
// Self-checking bench for the box versus four-plane frustum cull pipeline.
// ----------------------------------------------------------------------------
// Boxes go in through a bursty valid/ready driver, and cull flags are taken
// by a monitor that stalls on its own pattern. An in-bench model of the
// positive-vertex test predicts each flag when its box transaction is
// accepted. Plane settings change only while the pipeline is empty: reset
// planes, a hand-built axis frustum, extreme values, then random planes
// with random boxes. One random phase holds the result side off long
// enough for the pipeline to fill and push back on the box side.
// ----------------------------------------------------------------------------

module tb_aabb_frustum_cull;
    import afc_pkg::*;

    localparam int PipeDepth     = 4;
    localparam int SettleCycles  = PipeDepth + 6;
    localparam int HoldOffCycles = 300;
    localparam int RandomPhases  = 5;
    localparam int BoxesPerPhase = 80;
    // About 420 boxes; even with long gaps, stalls and the hold-off, a
    // correct run stays far below this.
    localparam int CycleLimit    = 200000;

    localparam coord_t CoordMin = coord_t'(20'h80000);
    localparam coord_t CoordMax = coord_t'(20'h7FFFF);
    localparam comp_t  CompMin  = comp_t'(16'h8000);
    localparam comp_t  CompMax  = comp_t'(16'h7FFF);
    localparam comp_t  CompOne  = comp_t'(16'h4000);
    localparam dist_t  DistMin  = dist_t'(21'h100000);
    localparam dist_t  DistMax  = dist_t'(21'h0FFFFF);

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    logic box_valid = 1'b0;
    box_t box_data = '0;
    logic res_ready = 1'b0;

    afc_box_if    box_ch ();
    afc_result_if res_ch ();

    assign box_ch.valid     = box_valid;
    assign box_ch.box_min_x = box_data.min_x;
    assign box_ch.box_min_y = box_data.min_y;
    assign box_ch.box_min_z = box_data.min_z;
    assign box_ch.box_max_x = box_data.max_x;
    assign box_ch.box_max_y = box_data.max_y;
    assign box_ch.box_max_z = box_data.max_z;
    assign res_ch.ready     = res_ready;

    aabb_frustum_cull u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .box       (box_ch),
        .result    (res_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bench copy of the plane registers.
    logic [NormalW-1:0] plane_normal_q [NumPlanes];
    dist_t              plane_dist_q [NumPlanes];

    box_t boxes_to_send [$];
    logic cull_flags_due [$];

    int failures        = 0;
    int boxes_accepted  = 0;
    int results_checked = 0;
    int culled_seen     = 0;
    int input_stalls    = 0;
    int plane_settings  = 0;
    int cycle_count     = 0;
    int hold_requests   = 0;
    int holds_served;
    int hold_left;
    int burst_left;
    int gap_left;
    logic [15:0] stall_pattern;
    logic [3:0]  stall_pos;
    logic        want_culled;

    // Positive-vertex test: per axis the corner furthest along the normal,
    // dot product at full precision against the distance moved to Q.18.
    function automatic logic box_outside_frustum(input box_t b);
        coord_t lo [NumAxes];
        coord_t hi [NumAxes];
        comp_t  n;
        longint dot;
        logic   outside;
        lo[0] = b.min_x;
        lo[1] = b.min_y;
        lo[2] = b.min_z;
        hi[0] = b.max_x;
        hi[1] = b.max_y;
        hi[2] = b.max_z;
        outside = 1'b0;
        for (int p = 0; p < NumPlanes; p++)
        begin
            dot = 0;
            for (int j = 0; j < NumAxes; j++)
            begin
                n = plane_normal_q[p][j*CompW +: CompW];
                dot += longint'(n) * longint'((n < 0) ? lo[j] : hi[j]);
            end
            if (dot < longint'(plane_dist_q[p]) * (longint'(1) << DistShift))
                outside = 1'b1;
        end
        return outside;
    endfunction

    function automatic logic [CfgIdxW-1:0] plane_reg(input int p, input bit is_dist);
        case (p)
            0:       return is_dist ? RegPlaneADist : RegPlaneANormal;
            1:       return is_dist ? RegPlaneBDist : RegPlaneBNormal;
            2:       return is_dist ? RegPlaneCDist : RegPlaneCNormal;
            default: return is_dist ? RegPlaneDDist : RegPlaneDNormal;
        endcase
    endfunction

    function automatic logic [NormalW-1:0] pack_normal(input comp_t x, input comp_t y,
                                                       input comp_t z);
        return {z, y, x};
    endfunction

    function automatic box_t make_box(input coord_t min_x, input coord_t min_y,
                                      input coord_t min_z, input coord_t max_x,
                                      input coord_t max_y, input coord_t max_z);
        box_t b;
        b.min_x = min_x;
        b.min_y = min_y;
        b.min_z = min_z;
        b.max_x = max_x;
        b.max_y = max_y;
        b.max_z = max_z;
        return b;
    endfunction

    function automatic comp_t rand_comp();
        case ($urandom_range(0, 11))
            0:       return CompMin;
            1:       return CompMax;
            2:       return '0;
            3:       return CompOne;
            4:       return -CompOne;
            default: return comp_t'($urandom());
        endcase
    endfunction

    function automatic coord_t rand_coord(input bit wide);
        if (!wide)
            return coord_t'(int'($urandom_range(0, 4095)) - 2048);
        case ($urandom_range(0, 11))
            0:       return CoordMin;
            1:       return CoordMax;
            2:       return '0;
            3:       return '1;
            default: return coord_t'($urandom());
        endcase
    endfunction

    // Most boxes are ordered per axis; the rest may come in inverted.
    function automatic box_t rand_box();
        coord_t a [NumAxes];
        coord_t b [NumAxes];
        coord_t t;
        bit     wide;
        bit     ordered;
        wide    = ($urandom_range(0, 5) == 0);
        ordered = ($urandom_range(0, 6) != 0);
        for (int j = 0; j < NumAxes; j++)
        begin
            a[j] = rand_coord(wide);
            b[j] = rand_coord(wide);
            if (ordered && a[j] > b[j])
            begin
                t    = a[j];
                a[j] = b[j];
                b[j] = t;
            end
        end
        return make_box(a[0], a[1], a[2], b[0], b[1], b[2]);
    endfunction

    // Dist writes carry random upper bits, which the register must drop.
    task automatic load_planes(input logic [NormalW-1:0] normals [NumPlanes],
                               input dist_t dists [NumPlanes]);
        logic [CfgDataW-DistW-1:0] junk;
        for (int p = 0; p < NumPlanes; p++)
        begin
            junk = (CfgDataW-DistW)'({$urandom(), $urandom()});
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= plane_reg(p, 1'b0);
            cfg_data  <= normals[p];
            plane_normal_q[p] = normals[p];
            @(posedge clk);
            cfg_index <= plane_reg(p, 1'b1);
            cfg_data  <= {junk, dists[p]};
            plane_dist_q[p] = dists[p];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        plane_settings++;
    endtask

    // Checked at the falling edge, once the driver and monitor have settled.
    task automatic drain();
        while (boxes_to_send.size() != 0 || box_valid || cull_flags_due.size() != 0)
            @(negedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic flag_failure(input string what);
        failures++;
        if (failures <= 10)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Box driver: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_valid  <= 1'b0;
            box_data   <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (box_valid && box_ch.ready)
            begin
                cull_flags_due.push_back(box_outside_frustum(box_data));
                boxes_accepted++;
            end
            if (box_valid && !box_ch.ready)
                input_stalls++;
            if (!box_valid || box_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left  <= gap_left - 1;
                    box_valid <= 1'b0;
                end
                else if (boxes_to_send.size() != 0)
                begin
                    box_valid <= 1'b1;
                    box_data  <= boxes_to_send.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    box_valid <= 1'b0;
            end
        end
    end

    // Long hold-off of the result side, started on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left    <= 0;
            holds_served <= 0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (holds_served != hold_requests)
        begin
            holds_served <= holds_served + 1;
            hold_left    <= HoldOffCycles;
        end
    end

    // Result monitor: checks every transaction, stalls on a 16-bit pattern
    // that is redrawn each time it runs out.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready     <= 1'b0;
            stall_pattern <= '1;
            stall_pos     <= '0;
        end
        else
        begin
            if (res_ch.valid && res_ready)
            begin
                if (cull_flags_due.size() == 0)
                    flag_failure($sformatf("culled=%0b arrived with no box outstanding",
                                           res_ch.culled));
                else
                begin
                    want_culled = cull_flags_due.pop_front();
                    if (res_ch.culled !== want_culled)
                        flag_failure($sformatf("result %0d: expected culled=%0b, actual %0b",
                                               results_checked, want_culled, res_ch.culled));
                    if (res_ch.culled === 1'b1)
                        culled_seen++;
                    results_checked++;
                end
            end
            if (stall_pos == 4'hF)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern <= '1;
                    1:       stall_pattern <= 16'($urandom());
                    default: stall_pattern <= 16'($urandom() | $urandom());
                endcase
            end
            stall_pos <= stall_pos + 1'b1;
            res_ready <= (hold_left == 0) && stall_pattern[stall_pos];
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, cull_flags_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        logic [NormalW-1:0] normals [NumPlanes];
        dist_t              dists [NumPlanes];

        for (int p = 0; p < NumPlanes; p++)
        begin
            plane_normal_q[p] = '0;
            plane_dist_q[p]   = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset planes: zero normals with zero distance never cull.
        boxes_to_send.push_back(make_box(CoordMin, CoordMin, CoordMin,
                                         CoordMax, CoordMax, CoordMax));
        boxes_to_send.push_back(make_box(CoordMax, CoordMax, CoordMax,
                                         CoordMin, CoordMin, CoordMin));
        boxes_to_send.push_back(make_box('0, '0, '0, '0, '0, '0));
        boxes_to_send.push_back(make_box('1, '1, '1, '1, '1, '1));
        drain();

        // Axis frustum: x >= -100, x <= 100, y >= -100, y <= 100 (Q16.4).
        // The z components stay zero, so the max corner is picked there.
        normals[0] = pack_normal(CompOne, '0, '0);
        dists[0]   = dist_t'(-1600);
        normals[1] = pack_normal(-CompOne, '0, '0);
        dists[1]   = dist_t'(-1600);
        normals[2] = pack_normal('0, CompOne, '0);
        dists[2]   = dist_t'(-1600);
        normals[3] = pack_normal('0, CompMin, '0);
        dists[3]   = dist_t'(-3200);
        load_planes(normals, dists);
        boxes_to_send.push_back(make_box(-20'sd16, -20'sd16, -20'sd16,
                                         20'sd16, 20'sd16, 20'sd16));
        boxes_to_send.push_back(make_box(-20'sd2000, 20'sd0, 20'sd0,
                                         -20'sd1700, 20'sd10, 20'sd10));
        boxes_to_send.push_back(make_box(20'sd1700, 20'sd0, 20'sd0,
                                         20'sd2000, 20'sd10, 20'sd10));
        boxes_to_send.push_back(make_box(20'sd0, -20'sd2000, 20'sd0,
                                         20'sd10, -20'sd1700, 20'sd10));
        boxes_to_send.push_back(make_box(20'sd0, 20'sd1700, 20'sd0,
                                         20'sd10, 20'sd2000, 20'sd10));
        // Touching the plane exactly is still inside; one step past is out.
        boxes_to_send.push_back(make_box(-20'sd2000, 20'sd0, 20'sd0,
                                         -20'sd1600, 20'sd0, 20'sd0));
        boxes_to_send.push_back(make_box(-20'sd2000, 20'sd0, 20'sd0,
                                         -20'sd1601, 20'sd0, 20'sd0));
        // Inverted boxes are used as given, with no swap.
        boxes_to_send.push_back(make_box(20'sd2000, 20'sd0, 20'sd0,
                                         -20'sd2000, 20'sd0, 20'sd0));
        boxes_to_send.push_back(make_box(20'sd100, 20'sd0, 20'sd0,
                                         -20'sd100, 20'sd0, 20'sd0));
        boxes_to_send.push_back(make_box('0, '0, CoordMin, '0, '0, CoordMax));
        drain();

        // Extreme normals and distances against extreme boxes.
        normals[0] = pack_normal(CompMax, CompMax, CompMax);
        dists[0]   = DistMax;
        normals[1] = pack_normal(CompMin, CompMin, CompMin);
        dists[1]   = DistMin;
        normals[2] = '0;
        dists[2]   = DistMin;
        normals[3] = pack_normal(CompMin, CompMax, '0);
        dists[3]   = '0;
        load_planes(normals, dists);
        boxes_to_send.push_back(make_box(CoordMax, CoordMax, CoordMax,
                                         CoordMax, CoordMax, CoordMax));
        boxes_to_send.push_back(make_box(CoordMin, CoordMin, CoordMin,
                                         CoordMin, CoordMin, CoordMin));
        boxes_to_send.push_back(make_box(CoordMin, CoordMin, CoordMin,
                                         CoordMax, CoordMax, CoordMax));
        boxes_to_send.push_back(make_box(CoordMax, CoordMin, CoordMax,
                                         CoordMin, CoordMax, CoordMin));
        boxes_to_send.push_back(make_box('0, '0, '0, '0, '0, '0));
        drain();

        for (int ph = 0; ph < RandomPhases; ph++)
        begin
            for (int p = 0; p < NumPlanes; p++)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    // A zero normal with a distance at or below zero is off.
                    normals[p] = '0;
                    dists[p]   = dist_t'(-int'($urandom_range(0, 1000)));
                end
                else
                begin
                    normals[p] = pack_normal(rand_comp(), rand_comp(), rand_comp());
                    case ($urandom_range(0, 7))
                        0:       dists[p] = dist_t'($urandom());
                        1:       dists[p] = ($urandom_range(0, 1) != 0) ? DistMax : DistMin;
                        default: dists[p] = dist_t'(int'($urandom_range(0, 8191)) - 4096);
                    endcase
                end
            end
            load_planes(normals, dists);
            for (int i = 0; i < BoxesPerPhase; i++)
                boxes_to_send.push_back(rand_box());
            if (ph == 1)
                hold_requests++;
            drain();
        end

        $display("checked %0d cull flags from %0d boxes under %0d plane settings",
                 results_checked, boxes_accepted, plane_settings);
        $display("%0d boxes culled, box side stalled for %0d cycles, %0d failures",
                 culled_seen, input_stalls, failures);
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
